/* rtl/core/wpg_pkg.sv */
// Package of shared constants, codes and types for the wear plausibility gate.
`default_nettype none

package wpg_pkg;

  localparam int unsigned MAX_EPOCHS = 4096;
  localparam int unsigned CNT_W      = $clog2(MAX_EPOCHS + 1);
  localparam int unsigned ACT_W      = 16;
  localparam int unsigned PCT_W      = 7;
  localparam int unsigned HR_W       = 16;
  localparam int unsigned SHARE_W    = 7;
  localparam int unsigned VERD_W     = 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned SHARE_SCALE = 100;
  // A scaled count reaches MAX_EPOCHS times one hundred.
  localparam int unsigned DIVD_W     = $clog2(MAX_EPOCHS * SHARE_SCALE + 1);
  localparam int unsigned STEP_W     = $clog2(SHARE_W);

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_EPOCHS    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MOVEMENT      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_HR_TRUST  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_WORN      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_PLAUSIBLE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_HR_SAMPLED    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_ABSENT_CODE   = 3'd6;

  localparam logic [VERD_W-1:0] VERDICT_WORN      = 2'd0;
  localparam logic [VERD_W-1:0] VERDICT_NOT_WORN  = 2'd1;
  localparam logic [VERD_W-1:0] VERDICT_UNCERTAIN = 2'd2;

  localparam logic [CNT_W-1:0]        RST_MIN_EPOCHS    = 13'd60;
  localparam logic [ACT_W-1:0]        RST_MOVEMENT      = 16'd2;
  localparam logic signed [HR_W-1:0]  RST_MIN_HR_TRUST  = 16'sd500;
  localparam logic [PCT_W-1:0]        RST_MIN_WORN      = 7'd50;
  localparam logic [PCT_W-1:0]        RST_MIN_PLAUSIBLE = 7'd20;
  localparam logic                    RST_HR_SAMPLED    = 1'b1;
  localparam logic signed [HR_W-1:0]  RST_ABSENT_CODE   = 16'sd32767;

  typedef struct packed {
    logic [CNT_W-1:0]       min_epochs;
    logic [ACT_W-1:0]       movement_floor;
    logic signed [HR_W-1:0] min_hr_trust;
    logic [PCT_W-1:0]       min_worn_pct;
    logic [PCT_W-1:0]       min_plausible_pct;
    logic                   hr_sampled;
    logic signed [HR_W-1:0] absent_code;
  } cfg_t;

  typedef struct packed {
    logic [VERD_W-1:0]  verdict;
    logic [CNT_W-1:0]   epoch_total;
    logic [CNT_W-1:0]   worn_total;
    logic [CNT_W-1:0]   moving_total;
    logic [CNT_W-1:0]   pulse_total;
    logic [CNT_W-1:0]   plausible_total;
    logic [SHARE_W-1:0] worn_share;
    logic [SHARE_W-1:0] plausible_share;
    logic               pulse_evidence;
    logic               worn_echo;
  } result_t;

  typedef struct packed {
    logic capture;
    logic update;
    logic div_start;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic last;
    logic div_done;
  } ctrl_sts_t;

endpackage

`default_nettype wire

/* rtl/core/wpg_if.sv */
// Interfaces of the epoch input channel and the result output channel.
`default_nettype none

interface wpg_epoch_if;
  logic                               valid;
  logic                               ready;
  logic [wpg_pkg::ACT_W-1:0]          activity_count;
  logic [wpg_pkg::PCT_W-1:0]          worn_percent;
  logic signed [wpg_pkg::HR_W-1:0]    hr_mean_tenths;
  logic signed [wpg_pkg::HR_W-1:0]    hr_trust_tenths;
  logic                               worn_reported;
  logic                               last_epoch;

  modport source (
    output valid, activity_count, worn_percent, hr_mean_tenths, hr_trust_tenths,
           worn_reported, last_epoch,
    input  ready
  );
  modport sink (
    input  valid, activity_count, worn_percent, hr_mean_tenths, hr_trust_tenths,
           worn_reported, last_epoch,
    output ready
  );
endinterface

interface wpg_result_if;
  logic                         valid;
  logic                         ready;
  logic [wpg_pkg::VERD_W-1:0]   verdict;
  logic [wpg_pkg::CNT_W-1:0]    epoch_total;
  logic [wpg_pkg::CNT_W-1:0]    worn_total;
  logic [wpg_pkg::CNT_W-1:0]    moving_total;
  logic [wpg_pkg::CNT_W-1:0]    pulse_total;
  logic [wpg_pkg::CNT_W-1:0]    plausible_total;
  logic [wpg_pkg::SHARE_W-1:0]  worn_share;
  logic [wpg_pkg::SHARE_W-1:0]  plausible_share;
  logic                         pulse_evidence;
  logic                         worn_echo;

  modport source (
    output valid, verdict, epoch_total, worn_total, moving_total, pulse_total,
           plausible_total, worn_share, plausible_share, pulse_evidence, worn_echo,
    input  ready
  );
  modport sink (
    input  valid, verdict, epoch_total, worn_total, moving_total, pulse_total,
           plausible_total, worn_share, plausible_share, pulse_evidence, worn_echo,
    output ready
  );
endinterface

`default_nettype wire

/* rtl/core/wpg_cfg.sv */
// Configuration register file of the wear plausibility gate.
`default_nettype none

module wpg_cfg (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [wpg_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic [wpg_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  output wpg_pkg::cfg_t                           cfg_o
);

  wpg_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        wpg_pkg::CFG_MIN_EPOCHS:    cfg_d.min_epochs = cfg_wdata_i[wpg_pkg::CNT_W-1:0];
        wpg_pkg::CFG_MOVEMENT:      cfg_d.movement_floor = cfg_wdata_i[wpg_pkg::ACT_W-1:0];
        wpg_pkg::CFG_MIN_HR_TRUST:  cfg_d.min_hr_trust = cfg_wdata_i[wpg_pkg::HR_W-1:0];
        wpg_pkg::CFG_MIN_WORN:      cfg_d.min_worn_pct = cfg_wdata_i[wpg_pkg::PCT_W-1:0];
        wpg_pkg::CFG_MIN_PLAUSIBLE: cfg_d.min_plausible_pct = cfg_wdata_i[wpg_pkg::PCT_W-1:0];
        wpg_pkg::CFG_HR_SAMPLED:    cfg_d.hr_sampled = cfg_wdata_i[0];
        wpg_pkg::CFG_ABSENT_CODE:   cfg_d.absent_code = cfg_wdata_i[wpg_pkg::HR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_epochs        <= wpg_pkg::RST_MIN_EPOCHS;
      cfg_q.movement_floor    <= wpg_pkg::RST_MOVEMENT;
      cfg_q.min_hr_trust      <= wpg_pkg::RST_MIN_HR_TRUST;
      cfg_q.min_worn_pct      <= wpg_pkg::RST_MIN_WORN;
      cfg_q.min_plausible_pct <= wpg_pkg::RST_MIN_PLAUSIBLE;
      cfg_q.hr_sampled        <= wpg_pkg::RST_HR_SAMPLED;
      cfg_q.absent_code       <= wpg_pkg::RST_ABSENT_CODE;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

/* rtl/core/wpg_div.sv */
// Restoring divider that yields one quotient bit per cycle for a share.
`default_nettype none

module wpg_div (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start_i,
  input  wire logic [wpg_pkg::DIVD_W-1:0]      dividend_i,
  input  wire logic [wpg_pkg::CNT_W-1:0]       divisor_i,
  output logic                                 done_o,
  output logic [wpg_pkg::SHARE_W-1:0]          quot_o
);

  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [wpg_pkg::STEP_W-1:0]    step_q, step_d;
  logic [wpg_pkg::DIVD_W-1:0]    rem_q, rem_d;
  logic [wpg_pkg::CNT_W-1:0]     dvs_q, dvs_d;
  logic [wpg_pkg::SHARE_W-1:0]   quot_q, quot_d;
  logic [wpg_pkg::DIVD_W-1:0]    trial;

  // The quotient of a share is known to stay below two to the SHARE_W.
  assign trial = wpg_pkg::DIVD_W'(dvs_q) << step_q;

  always_comb begin
    busy_d = busy_q;
    done_d = done_q;
    step_d = step_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quot_d = quot_q;
    if (start_i) begin
      busy_d = 1'b1;
      done_d = 1'b0;
      step_d = wpg_pkg::STEP_W'(wpg_pkg::SHARE_W - 1);
      rem_d  = dividend_i;
      dvs_d  = divisor_i;
      quot_d = '0;
    end else if (busy_q) begin
      if (rem_q >= trial) begin
        rem_d          = rem_q - trial;
        quot_d[step_q] = 1'b1;
      end
      if (step_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        step_d = step_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
    quot_q <= quot_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

`default_nettype wire

/* rtl/core/wpg_dp.sv */
// Datapath: epoch register, class counters, share dividers and result register.
`default_nettype none

module wpg_dp (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire wpg_pkg::cfg_t                   cfg_i,
  input  wire wpg_pkg::ctrl_cmd_t              cmd_i,
  output wpg_pkg::ctrl_sts_t                   sts_o,
  input  wire logic [wpg_pkg::ACT_W-1:0]       activity_count_i,
  input  wire logic [wpg_pkg::PCT_W-1:0]       worn_percent_i,
  input  wire logic signed [wpg_pkg::HR_W-1:0] hr_mean_tenths_i,
  input  wire logic signed [wpg_pkg::HR_W-1:0] hr_trust_tenths_i,
  input  wire logic                            worn_reported_i,
  input  wire logic                            last_epoch_i,
  output wpg_pkg::result_t                     result_o
);

  localparam logic [wpg_pkg::CNT_W-1:0] CntMax = wpg_pkg::CNT_W'(wpg_pkg::MAX_EPOCHS);

  logic [wpg_pkg::ACT_W-1:0]        act_q;
  logic [wpg_pkg::PCT_W-1:0]        wpct_q;
  logic signed [wpg_pkg::HR_W-1:0]  hr_q;
  logic signed [wpg_pkg::HR_W-1:0]  trust_q;
  logic                             echo_q;
  logic                             last_q;

  logic [wpg_pkg::CNT_W-1:0] epoch_cnt_q, epoch_cnt_d;
  logic [wpg_pkg::CNT_W-1:0] worn_cnt_q, worn_cnt_d;
  logic [wpg_pkg::CNT_W-1:0] moving_cnt_q, moving_cnt_d;
  logic [wpg_pkg::CNT_W-1:0] pulse_cnt_q, pulse_cnt_d;
  logic [wpg_pkg::CNT_W-1:0] plaus_cnt_q, plaus_cnt_d;

  wpg_pkg::result_t res_q, res_d;

  logic is_worn, is_moving, is_pulse, is_plaus;
  logic too_few;
  logic worn_done, plaus_done;
  logic [wpg_pkg::SHARE_W-1:0] worn_quot, plaus_quot;
  logic [wpg_pkg::DIVD_W-1:0]  worn_scaled, plaus_scaled;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      act_q   <= activity_count_i;
      wpct_q  <= worn_percent_i;
      hr_q    <= hr_mean_tenths_i;
      trust_q <= hr_trust_tenths_i;
      echo_q  <= worn_reported_i;
      last_q  <= last_epoch_i;
    end
  end

  assign is_worn   = wpct_q >= cfg_i.min_worn_pct;
  assign is_moving = act_q > cfg_i.movement_floor;
  assign is_pulse  = (hr_q != cfg_i.absent_code) && (hr_q > 16'sd0) &&
                     (trust_q != cfg_i.absent_code) && (trust_q >= cfg_i.min_hr_trust);
  assign is_plaus  = is_moving || (cfg_i.hr_sampled && is_pulse);

  function automatic logic [wpg_pkg::CNT_W-1:0] bump(input logic [wpg_pkg::CNT_W-1:0] c,
                                                      input logic hit);
    logic [wpg_pkg::CNT_W-1:0] r;
    r = c;
    if (hit && (c < CntMax)) begin
      r = c + 1'b1;
    end
    return r;
  endfunction

  always_comb begin
    epoch_cnt_d  = epoch_cnt_q;
    worn_cnt_d   = worn_cnt_q;
    moving_cnt_d = moving_cnt_q;
    pulse_cnt_d  = pulse_cnt_q;
    plaus_cnt_d  = plaus_cnt_q;
    if (cmd_i.load_out) begin
      epoch_cnt_d  = '0;
      worn_cnt_d   = '0;
      moving_cnt_d = '0;
      pulse_cnt_d  = '0;
      plaus_cnt_d  = '0;
    end else if (cmd_i.update) begin
      epoch_cnt_d  = bump(epoch_cnt_q, 1'b1);
      worn_cnt_d   = bump(worn_cnt_q, is_worn);
      moving_cnt_d = bump(moving_cnt_q, is_moving);
      pulse_cnt_d  = bump(pulse_cnt_q, is_pulse);
      plaus_cnt_d  = bump(plaus_cnt_q, is_plaus);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      epoch_cnt_q  <= '0;
      worn_cnt_q   <= '0;
      moving_cnt_q <= '0;
      pulse_cnt_q  <= '0;
      plaus_cnt_q  <= '0;
    end else begin
      epoch_cnt_q  <= epoch_cnt_d;
      worn_cnt_q   <= worn_cnt_d;
      moving_cnt_q <= moving_cnt_d;
      pulse_cnt_q  <= pulse_cnt_d;
      plaus_cnt_q  <= plaus_cnt_d;
    end
  end

  assign worn_scaled  = wpg_pkg::DIVD_W'(worn_cnt_q) *
                        wpg_pkg::DIVD_W'(wpg_pkg::SHARE_SCALE);
  assign plaus_scaled = wpg_pkg::DIVD_W'(plaus_cnt_q) *
                        wpg_pkg::DIVD_W'(wpg_pkg::SHARE_SCALE);

  wpg_div u_worn_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (worn_scaled),
    .divisor_i  (epoch_cnt_q),
    .done_o     (worn_done),
    .quot_o     (worn_quot)
  );

  wpg_div u_plaus_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (plaus_scaled),
    .divisor_i  (epoch_cnt_q),
    .done_o     (plaus_done),
    .quot_o     (plaus_quot)
  );

  assign too_few = (epoch_cnt_q < cfg_i.min_epochs) || (epoch_cnt_q == '0);

  always_comb begin
    res_d = res_q;
    if (cmd_i.load_out) begin
      res_d.epoch_total    = epoch_cnt_q;
      res_d.pulse_evidence = cfg_i.hr_sampled;
      res_d.worn_echo      = echo_q;
      if (too_few) begin
        res_d.verdict         = wpg_pkg::VERDICT_UNCERTAIN;
        res_d.worn_total      = '0;
        res_d.moving_total    = '0;
        res_d.pulse_total     = '0;
        res_d.plausible_total = '0;
        res_d.worn_share      = '0;
        res_d.plausible_share = '0;
      end else begin
        res_d.worn_total      = worn_cnt_q;
        res_d.moving_total    = moving_cnt_q;
        res_d.pulse_total     = pulse_cnt_q;
        res_d.plausible_total = plaus_cnt_q;
        res_d.worn_share      = worn_quot;
        res_d.plausible_share = plaus_quot;
        if (plaus_quot < cfg_i.min_plausible_pct) begin
          res_d.verdict = wpg_pkg::VERDICT_NOT_WORN;
        end else if (!cfg_i.hr_sampled) begin
          res_d.verdict = wpg_pkg::VERDICT_UNCERTAIN;
        end else begin
          res_d.verdict = wpg_pkg::VERDICT_WORN;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign sts_o.last     = last_q;
  assign sts_o.div_done = worn_done && plaus_done;
  assign result_o       = res_q;

  // Neither the worn nor the plausible counter may run ahead of the epoch counter.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (worn_cnt_q <= epoch_cnt_q) && (plaus_cnt_q <= epoch_cnt_q))
    else $error("class counter above epoch counter");

  // Both share dividers run in lockstep.
  assert property (@(posedge clk_i) disable iff (!rst_ni) worn_done == plaus_done)
    else $error("share dividers out of step");

endmodule

`default_nettype wire

/* rtl/core/wpg_ctrl.sv */
// Controller state machine that sequences capture, update, division and result load.
`default_nettype none

module wpg_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  input  wire wpg_pkg::ctrl_sts_t sts_i,
  output wpg_pkg::ctrl_cmd_t cmd_o
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_UPDATE = 2'd1;
  localparam logic [1:0] S_START  = 2'd2;
  localparam logic [1:0] S_DIV    = 2'd3;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_UPDATE;
        end
      end
      S_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d      = sts_i.last ? S_START : S_IDLE;
      end
      S_START: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_DIV;
      end
      S_DIV: begin
        if (sts_i.div_done && out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  // An accepted word is always folded into the counters on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_UPDATE))
    else $error("accepted word not followed by counter update");

  // A new result never overwrites one that is still waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten while pending");

  // The dividers are started only once the last epoch has been counted.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_start |-> $past(cmd_o.update) && sts_i.last)
    else $error("division started without a counted last epoch");

endmodule

`default_nettype wire

/* rtl/core/wear_plausibility_gate.sv */
// Top level of the wear plausibility gate: config registers, controller and datapath.
//
// Channel   Direction  Handshake       Word
// epoch_i   in         valid/ready     one sleep epoch
// result_o  out        valid/ready     one night summary, on the last epoch only
// cfg       in         cfg_we_i        register index and write data
//
// An epoch that is not the last passes through capture, then counter update.
// The last epoch then goes on to divider start and division, in which the two
// share dividers run in parallel and retire one quotient bit per cycle.
// The result sits in an output register; epochs are taken while it waits, and
// only the next night's result waits for it to be taken.
// Reset clears the counters and the controller, and sets the config registers to their defaults.
`default_nettype none

module wear_plausibility_gate (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  wpg_epoch_if.sink                            epoch_i,
  wpg_result_if.source                         result_o,
  input  wire logic                            cfg_we_i,
  input  wire logic [wpg_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [wpg_pkg::CFG_DATA_W-1:0]  cfg_wdata_i
);

  wpg_pkg::cfg_t      cfg;
  wpg_pkg::ctrl_cmd_t cmd;
  wpg_pkg::ctrl_sts_t sts;
  wpg_pkg::result_t   res;

  wpg_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  wpg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (epoch_i.valid),
    .in_ready_o  (epoch_i.ready),
    .out_valid_o (result_o.valid),
    .out_ready_i (result_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  wpg_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .activity_count_i  (epoch_i.activity_count),
    .worn_percent_i    (epoch_i.worn_percent),
    .hr_mean_tenths_i  (epoch_i.hr_mean_tenths),
    .hr_trust_tenths_i (epoch_i.hr_trust_tenths),
    .worn_reported_i   (epoch_i.worn_reported),
    .last_epoch_i      (epoch_i.last_epoch),
    .result_o          (res)
  );

  assign result_o.verdict         = res.verdict;
  assign result_o.epoch_total     = res.epoch_total;
  assign result_o.worn_total      = res.worn_total;
  assign result_o.moving_total    = res.moving_total;
  assign result_o.pulse_total     = res.pulse_total;
  assign result_o.plausible_total = res.plausible_total;
  assign result_o.worn_share      = res.worn_share;
  assign result_o.plausible_share = res.plausible_share;
  assign result_o.pulse_evidence  = res.pulse_evidence;
  assign result_o.worn_echo       = res.worn_echo;

endmodule

`default_nettype wire

/* sim/tb.sv */
// Self-checking testbench for the wear plausibility gate: predicts each night summary and compares it.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import wpg_pkg::*;

  localparam int QUIET_LIMIT = 4000;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 20;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

  typedef struct packed {
    logic [ACT_W-1:0]       activity_count;
    logic [PCT_W-1:0]       worn_percent;
    logic signed [HR_W-1:0] hr_mean_tenths;
    logic signed [HR_W-1:0] hr_trust_tenths;
    logic                   worn_reported;
    logic                   last_epoch;
  } epoch_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  wpg_epoch_if  epoch_bus ();
  wpg_result_if summary_bus ();

  wear_plausibility_gate u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .epoch_i     (epoch_bus),
    .result_o    (summary_bus),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #6ns clk_i = ~clk_i;

  cfg_t night_cfg;
  logic [CNT_W-1:0] tally_epochs, tally_worn, tally_moving, tally_pulse, tally_plausible;

  epoch_t  epochs_pending[$];
  result_t summaries_due[$];

  logic epoch_taken = 1'b0;
  logic calm = 1'b0;
  logic hold_req = 1'b0;
  logic hold_used = 1'b0;
  int send_gap = 0;
  int stall_left = 0;
  int hold_left = 0;
  int quiet_cycles = 0;
  int mismatches = 0;
  int summaries_checked = 0;
  int epochs_queued = 0;
  int regs_written = 0;

  function automatic logic [CNT_W-1:0] bumped(logic [CNT_W-1:0] c);
    return (c < MAX_EPOCHS) ? c + 1'b1 : c;
  endfunction

  function automatic bit predict_epoch(input epoch_t e, output result_t s);
    logic signed [HR_W-1:0] hr, trust, trust_floor, absent;
    logic worn_hit, moving_hit, pulse_hit;
    int unsigned n, wsh, psh;
    hr = e.hr_mean_tenths;
    trust = e.hr_trust_tenths;
    trust_floor = night_cfg.min_hr_trust;
    absent = night_cfg.absent_code;
    worn_hit = e.worn_percent >= night_cfg.min_worn_pct;
    moving_hit = e.activity_count > night_cfg.movement_floor;
    pulse_hit = hr != absent && hr > 16'sd0 && trust != absent && trust >= trust_floor;
    tally_epochs = bumped(tally_epochs);
    if (worn_hit) tally_worn = bumped(tally_worn);
    if (moving_hit) tally_moving = bumped(tally_moving);
    if (pulse_hit) tally_pulse = bumped(tally_pulse);
    if (moving_hit || (night_cfg.hr_sampled && pulse_hit)) tally_plausible = bumped(tally_plausible);
    s = '0;
    if (!e.last_epoch) return 1'b0;
    n = tally_epochs;
    s.epoch_total = tally_epochs;
    s.pulse_evidence = night_cfg.hr_sampled;
    s.worn_echo = e.worn_reported;
    if (n < night_cfg.min_epochs) begin
      s.verdict = VERDICT_UNCERTAIN;
    end else begin
      wsh = tally_worn * SHARE_SCALE / n;
      psh = tally_plausible * SHARE_SCALE / n;
      s.worn_total = tally_worn;
      s.moving_total = tally_moving;
      s.pulse_total = tally_pulse;
      s.plausible_total = tally_plausible;
      s.worn_share = wsh[SHARE_W-1:0];
      s.plausible_share = psh[SHARE_W-1:0];
      if (psh < night_cfg.min_plausible_pct) s.verdict = VERDICT_NOT_WORN;
      else if (!night_cfg.hr_sampled) s.verdict = VERDICT_UNCERTAIN;
      else s.verdict = VERDICT_WORN;
    end
    tally_epochs = '0;
    tally_worn = '0;
    tally_moving = '0;
    tally_pulse = '0;
    tally_plausible = '0;
    return 1'b1;
  endfunction

  task automatic report_mismatch(string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic compare_field(string field, int got, int want);
    if (got !== want)
      report_mismatch($sformatf("summary %0d %s got %0d, expected %0d",
                                summaries_checked, field, got, want));
  endtask

  task automatic check_summary(result_t got, result_t want);
    compare_field("verdict", got.verdict, want.verdict);
    compare_field("epoch_total", got.epoch_total, want.epoch_total);
    compare_field("worn_total", got.worn_total, want.worn_total);
    compare_field("moving_total", got.moving_total, want.moving_total);
    compare_field("pulse_total", got.pulse_total, want.pulse_total);
    compare_field("plausible_total", got.plausible_total, want.plausible_total);
    compare_field("worn_share", got.worn_share, want.worn_share);
    compare_field("plausible_share", got.plausible_share, want.plausible_share);
    compare_field("pulse_evidence", got.pulse_evidence, want.pulse_evidence);
    compare_field("worn_echo", got.worn_echo, want.worn_echo);
  endtask

  // Epoch driver: a word stays on the bus until it is taken.
  always @(negedge clk_i) begin
    epoch_t next_word;
    if (rst_ni && (!epoch_bus.valid || epoch_taken)) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        epoch_bus.valid <= 1'b0;
      end else if (epochs_pending.size() != 0 && !calm && $urandom_range(0, 9) == 0) begin
        send_gap <= $urandom_range(0, 5);
        epoch_bus.valid <= 1'b0;
      end else if (epochs_pending.size() != 0) begin
        next_word = epochs_pending.pop_front();
        epoch_bus.activity_count <= next_word.activity_count;
        epoch_bus.worn_percent <= next_word.worn_percent;
        epoch_bus.hr_mean_tenths <= next_word.hr_mean_tenths;
        epoch_bus.hr_trust_tenths <= next_word.hr_trust_tenths;
        epoch_bus.worn_reported <= next_word.worn_reported;
        epoch_bus.last_epoch <= next_word.last_epoch;
        epoch_bus.valid <= 1'b1;
      end else begin
        epoch_bus.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        summary_bus.ready <= 1'b0;
      end else if (hold_req && !hold_used) begin
        hold_used <= 1'b1;
        hold_left <= HOLD_CYCLES;
        summary_bus.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        summary_bus.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        stall_left <= $urandom_range(0, 5);
        summary_bus.ready <= 1'b0;
      end else begin
        summary_bus.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : watch
    epoch_t  seen;
    result_t got, want;
    epoch_taken <= epoch_bus.valid && epoch_bus.ready;
    if (rst_ni) begin
      if (epoch_bus.valid && epoch_bus.ready) begin
        seen.activity_count = epoch_bus.activity_count;
        seen.worn_percent = epoch_bus.worn_percent;
        seen.hr_mean_tenths = epoch_bus.hr_mean_tenths;
        seen.hr_trust_tenths = epoch_bus.hr_trust_tenths;
        seen.worn_reported = epoch_bus.worn_reported;
        seen.last_epoch = epoch_bus.last_epoch;
        if (predict_epoch(seen, want)) summaries_due.push_back(want);
      end
      if (summary_bus.valid && summary_bus.ready) begin
        got.verdict = summary_bus.verdict;
        got.epoch_total = summary_bus.epoch_total;
        got.worn_total = summary_bus.worn_total;
        got.moving_total = summary_bus.moving_total;
        got.pulse_total = summary_bus.pulse_total;
        got.plausible_total = summary_bus.plausible_total;
        got.worn_share = summary_bus.worn_share;
        got.plausible_share = summary_bus.plausible_share;
        got.pulse_evidence = summary_bus.pulse_evidence;
        got.worn_echo = summary_bus.worn_echo;
        if (summaries_due.size() == 0) begin
          report_mismatch("summary word arrived with no night pending");
        end else begin
          check_summary(got, summaries_due.pop_front());
        end
        summaries_checked++;
      end
      if ((epoch_bus.valid && epoch_bus.ready) || (summary_bus.valid && summary_bus.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", QUIET_LIMIT);
        $display("FAILED: results differ");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_MIN_EPOCHS:    night_cfg.min_epochs = data[CNT_W-1:0];
      CFG_MOVEMENT:      night_cfg.movement_floor = data;
      CFG_MIN_HR_TRUST:  night_cfg.min_hr_trust = data;
      CFG_MIN_WORN:      night_cfg.min_worn_pct = data[PCT_W-1:0];
      CFG_MIN_PLAUSIBLE: night_cfg.min_plausible_pct = data[PCT_W-1:0];
      CFG_HR_SAMPLED:    night_cfg.hr_sampled = data[0];
      CFG_ABSENT_CODE:   night_cfg.absent_code = data;
      default: ;
    endcase
    regs_written++;
  endtask

  task automatic drain();
    while (epochs_pending.size() != 0 || epoch_bus.valid || summaries_due.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic void offer(epoch_t e);
    epochs_pending.push_back(e);
    epochs_queued++;
  endfunction

  function automatic void directed(int act, int wpct, int hr, int trust, bit worn, bit last);
    epoch_t e;
    e.activity_count = act;
    e.worn_percent = wpct;
    e.hr_mean_tenths = hr;
    e.hr_trust_tenths = trust;
    e.worn_reported = worn;
    e.last_epoch = last;
    offer(e);
  endfunction

  function automatic logic signed [HR_W-1:0] pick_reading(logic signed [HR_W-1:0] near);
    case ($urandom_range(0, 7))
      0: return night_cfg.absent_code;
      1: return near;
      2: return near - 16'sd1;
      3: return near + 16'sd1;
      4: return 16'sh7fff;
      5: return 16'sh8000;
      default: return $urandom;
    endcase
  endfunction

  function automatic epoch_t random_epoch();
    epoch_t e;
    case ($urandom_range(0, 6))
      0: e.activity_count = night_cfg.movement_floor;
      1: e.activity_count = night_cfg.movement_floor + 1'b1;
      2: e.activity_count = night_cfg.movement_floor - 1'b1;
      3: e.activity_count = '0;
      4: e.activity_count = '1;
      5: e.activity_count = $urandom_range(0, 10);
      default: e.activity_count = $urandom;
    endcase
    case ($urandom_range(0, 7))
      0: e.worn_percent = night_cfg.min_worn_pct;
      1: e.worn_percent = night_cfg.min_worn_pct - 1'b1;
      2: e.worn_percent = $urandom_range(101, 127);
      default: e.worn_percent = $urandom_range(0, 100);
    endcase
    e.hr_mean_tenths = pick_reading(16'sd1);
    e.hr_trust_tenths = pick_reading(night_cfg.min_hr_trust);
    e.worn_reported = $urandom;
    e.last_epoch = 1'b0;
    return e;
  endfunction

  function automatic int random_night(int len, bit mark_last);
    epoch_t e;
    for (int i = 0; i < len; i++) begin
      e = random_epoch();
      e.last_epoch = mark_last && (i == len - 1);
      offer(e);
    end
    return len;
  endfunction

  task automatic shuffle_settings();
    drain();
    case ($urandom_range(0, 7))
      0: write_reg(CFG_MIN_EPOCHS, 16'd0);
      1: write_reg(CFG_MIN_EPOCHS, 16'd4096);
      2: write_reg(CFG_MIN_EPOCHS, 16'd8191);
      default: write_reg(CFG_MIN_EPOCHS, $urandom_range(1, 10));
    endcase
    case ($urandom_range(0, 4))
      0: write_reg(CFG_MOVEMENT, 16'd0);
      1: write_reg(CFG_MOVEMENT, 16'hffff);
      2: write_reg(CFG_MOVEMENT, $urandom);
      default: write_reg(CFG_MOVEMENT, $urandom_range(0, 200));
    endcase
    case ($urandom_range(0, 4))
      0: write_reg(CFG_MIN_HR_TRUST, 16'h8000);
      1: write_reg(CFG_MIN_HR_TRUST, 16'h7fff);
      2: write_reg(CFG_MIN_HR_TRUST, $urandom);
      default: write_reg(CFG_MIN_HR_TRUST, $urandom_range(0, 1000));
    endcase
    case ($urandom_range(0, 4))
      0: write_reg(CFG_MIN_WORN, 16'd0);
      1: write_reg(CFG_MIN_WORN, 16'd100);
      2: write_reg(CFG_MIN_WORN, 16'd127);
      default: write_reg(CFG_MIN_WORN, $urandom_range(0, 100));
    endcase
    case ($urandom_range(0, 4))
      0: write_reg(CFG_MIN_PLAUSIBLE, 16'd0);
      1: write_reg(CFG_MIN_PLAUSIBLE, 16'd100);
      2: write_reg(CFG_MIN_PLAUSIBLE, 16'd127);
      default: write_reg(CFG_MIN_PLAUSIBLE, $urandom_range(0, 100));
    endcase
    write_reg(CFG_HR_SAMPLED, $urandom);
    case ($urandom_range(0, 5))
      0: write_reg(CFG_ABSENT_CODE, 16'h7fff);
      1: write_reg(CFG_ABSENT_CODE, 16'h8000);
      2: write_reg(CFG_ABSENT_CODE, 16'hffff);
      3: write_reg(CFG_ABSENT_CODE, 16'd0);
      default: write_reg(CFG_ABSENT_CODE, $urandom);
    endcase
  endtask

  initial begin
    int random_items, phase_items, len;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_wdata_i = '0;
    epoch_bus.valid = 1'b0;
    epoch_bus.activity_count = '0;
    epoch_bus.worn_percent = '0;
    epoch_bus.hr_mean_tenths = '0;
    epoch_bus.hr_trust_tenths = '0;
    epoch_bus.worn_reported = 1'b0;
    epoch_bus.last_epoch = 1'b0;
    summary_bus.ready = 1'b0;
    night_cfg.min_epochs = RST_MIN_EPOCHS;
    night_cfg.movement_floor = RST_MOVEMENT;
    night_cfg.min_hr_trust = RST_MIN_HR_TRUST;
    night_cfg.min_worn_pct = RST_MIN_WORN;
    night_cfg.min_plausible_pct = RST_MIN_PLAUSIBLE;
    night_cfg.hr_sampled = RST_HR_SAMPLED;
    night_cfg.absent_code = RST_ABSENT_CODE;
    tally_epochs = '0;
    tally_worn = '0;
    tally_moving = '0;
    tally_pulse = '0;
    tally_plausible = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: single-epoch nights fall short of the epoch floor.
    directed(0, 0, -32768, -32768, 0, 1);
    directed(65535, 127, 32767, 32767, 1, 1);
    drain();
    write_reg(CFG_MIN_EPOCHS, 16'd1);
    write_reg(CFG_UNUSED, 16'hffff);
    directed(3, 50, 1, 500, 1, 1);
    directed(2, 49, 0, 32767, 0, 1);
    directed(0, 100, 32767, 900, 1, 1);
    directed(0, 0, 700, 499, 0, 1);
    directed(0, 0, 700, 600, 0, 1);
    directed(3, 50, -5, 600, 0, 0);
    directed(0, 0, -5, 600, 0, 0);
    directed(0, 0, 0, 0, 1, 1);
    drain();
    write_reg(CFG_HR_SAMPLED, 16'd0);
    directed(0, 0, 700, 600, 0, 1);
    directed(3, 0, 700, 600, 1, 1);
    drain();
    write_reg(CFG_HR_SAMPLED, 16'd1);
    write_reg(CFG_MIN_EPOCHS, 16'd4);
    write_reg(CFG_MIN_PLAUSIBLE, 16'd100);
    directed(5, 60, 700, 600, 1, 0);
    directed(0, 60, 700, 600, 0, 0);
    directed(9, 10, 32767, 600, 0, 0);
    directed(0, 0, 0, 600, 1, 1);
    directed(5, 60, 700, 600, 1, 0);
    directed(5, 60, 700, 600, 1, 0);
    directed(5, 60, 700, 600, 0, 1);

    // Short nights while the result side holds off, so the output register fills.
    drain();
    write_reg(CFG_MIN_EPOCHS, 16'd1);
    write_reg(CFG_MIN_PLAUSIBLE, 16'd20);
    hold_req = 1'b1;
    for (int i = 0; i < 40; i++) void'(random_night($urandom_range(1, 3), 1'b1));

    random_items = 0;
    while (random_items < 850) begin
      if (random_items >= 700) calm = 1'b1;
      shuffle_settings();
      phase_items = 0;
      while (phase_items < 50) begin
        case ($urandom_range(0, 9))
          8: len = $urandom_range(11, 40);
          9: len = $urandom_range(41, 150);
          default: len = $urandom_range(1, 10);
        endcase
        phase_items += random_night(len, $urandom_range(0, 9) != 0);
      end
      random_items += phase_items;
    end

    // A short closing night ends any night that was left open.
    calm = 1'b1;
    void'(random_night(2, 1'b1));

    drain();
    $display("Covered %0d epoch words, %0d night summaries and %0d register writes,",
             epochs_queued, summaries_checked, regs_written);
    $display("including a %0d-cycle result hold-off that filled the output register.",
             HOLD_CYCLES);
    if (mismatches == 0 && summaries_due.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/wpg_pkg.sv
rtl/core/wpg_if.sv
rtl/core/wpg_cfg.sv
rtl/core/wpg_div.sv
rtl/core/wpg_dp.sv
rtl/core/wpg_ctrl.sv
rtl/core/wear_plausibility_gate.sv
sim/tb.sv
